// File: sv/di2cwf_pkg.sv
// ============================================================================
// di2cwf_pkg
// Types and constants for the display I2C write framer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package di2cwf_pkg;

  // bus symbol codes carried in the output word
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BIT   = 2'd1,
    KIND_ACK   = 2'd2,
    KIND_STOP  = 2'd3
  } sym_kind_t;

  // request types
  localparam logic REQ_COMMAND = 1'b0;
  localparam logic REQ_DATA    = 1'b1;

  // configuration register indexes
  localparam logic [7:0] REG_NORMAL_COLOUR = 8'd0;
  localparam logic [7:0] REG_DEV_ADDR      = 8'd1;

  // reset values of the configuration registers
  localparam logic       NORMAL_COLOUR_RST = 1'b1;
  localparam logic [7:0] DEV_ADDR_RST      = 8'h78;

  // control bytes sent after the address
  localparam logic [7:0] CTRL_COMMAND = 8'h00;
  localparam logic [7:0] CTRL_DATA    = 8'h40;

  // slot sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_BYTE  = 4'b0100,
    ST_STOP  = 4'b1000
  } seq_state_t;

  // byte slots within one transaction; the item's own byte is always the last
  localparam int unsigned NUM_BYTES = 3;
  localparam logic [1:0]  BYTE_LAST = 2'd2;

  // bit slots per byte: eight data bits, then the ack slot
  localparam logic [3:0]  ACK_SLOT = 4'd8;

endpackage

`default_nettype wire

// File: sv/display_i2c_write_framer_core.sv
// ============================================================================
// display_i2c_write_framer_core
// Frames display controller write requests into a stream of I2C bus symbols.
// ============================================================================
// Each accepted word is one request and yields one symbol word per cycle:
// a command gives 29 symbols (start, address, control 0x00, command, stop),
// a data byte gives 9 symbols plus 19 with first_byte and 1 with last_byte.
// The rate is set by the slot sequencer, which emits one symbol per cycle
// while the output is not stalled; the next request is taken in the cycle
// the current one emits its last symbol, so requests run back to back with
// no gap. An output register holds the symbol on stall. Configuration
// writes are taken every cycle and should be issued while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module display_i2c_write_framer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [7:0] byte_value, [8] first_byte, [15:9] zero
  input  wire logic        s_tuser,   // [0] req_type
  input  wire logic        s_tlast,   // last_byte
  // symbol stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [1:0] symbol_kind, [2] bit_level, [7:3] zero
  output logic             m_tlast,   // last_symbol
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  import di2cwf_pkg::*;

  // configuration registers
  logic       normal_colour;
  logic [7:0] dev_addr;

  // sequencer state
  seq_state_t state, state_next;
  logic [7:0] bytes [NUM_BYTES];
  logic [1:0] byte_sel, byte_sel_next;
  logic [3:0] bit_cnt, bit_cnt_next;
  logic       stop_pend;

  // slot symbol of the current cycle
  sym_kind_t  sym_kind;
  logic       sym_level;
  logic       sym_last;

  logic       out_ready;
  logic       advance;
  logic       cur_last;
  logic       s_accept;

  // request fields
  logic       req_type;
  logic [7:0] byte_value;
  logic       first_byte;
  logic       last_byte;
  logic [7:0] data_sent;

  assign req_type   = s_tuser;
  assign byte_value = s_tdata[7:0];
  assign first_byte = s_tdata[8];
  assign last_byte  = s_tlast;
  assign data_sent  = normal_colour ? byte_value : ~byte_value;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_colour <= NORMAL_COLOUR_RST;
      dev_addr      <= DEV_ADDR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NORMAL_COLOUR: normal_colour <= cfg_data[0];
        REG_DEV_ADDR:      dev_addr      <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_ready = !m_tvalid || m_tready;
  assign advance   = (state != ST_IDLE) && out_ready;
  assign cur_last  = (state == ST_STOP) ||
                     ((state == ST_BYTE) && (bit_cnt == ACK_SLOT) &&
                      (byte_sel == BYTE_LAST) && !stop_pend);
  assign s_tready  = (state == ST_IDLE) || (cur_last && out_ready);
  assign s_accept  = s_tvalid && s_tready;

  // symbol of the current slot
  always_comb begin
    sym_kind  = KIND_STOP;
    sym_level = 1'b0;
    sym_last  = 1'b0;
    unique case (state)
      ST_START: sym_kind = KIND_START;
      ST_BYTE: begin
        if (bit_cnt == ACK_SLOT) begin
          sym_kind  = KIND_ACK;
          sym_level = bytes[byte_sel][0];
          sym_last  = cur_last;
        end else begin
          sym_kind  = KIND_BIT;
          sym_level = bytes[byte_sel][3'(4'd7 - bit_cnt)];
        end
      end
      ST_STOP: begin
        sym_kind = KIND_STOP;
        sym_last = 1'b1;
      end
      default: ;
    endcase
  end

  // slot sequencing for the current request
  always_comb begin
    state_next    = state;
    byte_sel_next = byte_sel;
    bit_cnt_next  = bit_cnt;
    if (advance) begin
      unique case (state)
        ST_START: state_next = ST_BYTE;
        ST_BYTE: begin
          if (bit_cnt == ACK_SLOT) begin
            bit_cnt_next = 4'd0;
            if (byte_sel == BYTE_LAST) begin
              state_next = stop_pend ? ST_STOP : ST_IDLE;
            end else begin
              byte_sel_next = byte_sel + 2'd1;
            end
          end else begin
            bit_cnt_next = bit_cnt + 4'd1;
          end
        end
        ST_STOP: state_next = ST_IDLE;
        default: ;
      endcase
    end
    // load a new request into the sequencer
    if (s_accept) begin
      bit_cnt_next = 4'd0;
      if (req_type == REQ_COMMAND || first_byte) begin
        state_next    = ST_START;
        byte_sel_next = 2'd0;
      end else begin
        state_next    = ST_BYTE;
        byte_sel_next = BYTE_LAST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      byte_sel <= 2'd0;
      bit_cnt  <= 4'd0;
    end else begin
      state    <= state_next;
      byte_sel <= byte_sel_next;
      bit_cnt  <= bit_cnt_next;
    end
  end

  // byte payload of the request
  always_ff @(posedge clk) begin
    if (s_accept) begin
      bytes[0] <= dev_addr;
      if (req_type == REQ_COMMAND) begin
        bytes[1]  <= CTRL_COMMAND;
        bytes[2]  <= byte_value;
        stop_pend <= 1'b1;
      end else begin
        bytes[1]  <= CTRL_DATA;
        bytes[2]  <= data_sent;
        stop_pend <= last_byte;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= (state != ST_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      m_tdata <= {5'd0, sym_level, sym_kind};
      m_tlast <= sym_last;
    end
  end

  // checks
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[1:0] == KIND_ACK) || (m_tdata[1:0] == KIND_STOP))
    else $error("last symbol is not an ack or stop");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_BYTE |-> bit_cnt <= ACK_SLOT)
    else $error("bit slot counter out of range");

  a_busy_accept: assert property (@(posedge clk) disable iff (rst)
    s_accept && state != ST_IDLE |-> cur_last && out_ready)
    else $error("request taken before current one finished");

  a_start_first: assert property (@(posedge clk) disable iff (rst)
    state == ST_START |-> byte_sel == 2'd0 && bit_cnt == 4'd0)
    else $error("start slot with sequencer not at first byte");

endmodule

`default_nettype wire

// File: test/tb_display_i2c_write_framer_core.sv
// ============================================================================
// tb_display_i2c_write_framer_core
// Self-checking bench for the display I2C write framer.
// ============================================================================
// Requests go in on the slave stream and configuration on the register
// channel. A software copy of the framer expands every accepted request into
// the symbol words it must produce: start, address, control, data, ack and
// stop slots. The monitor checks each output word field by field against the
// oldest pending symbol. A directed section covers commands, framed and
// unframed data, inverted colour, address extremes and unused register
// indexes. Four random phases follow under different idle and stall rates.
`timescale 1ns / 1ps
`default_nettype none

module tb_display_i2c_write_framer_core;
  import di2cwf_pkg::*;

  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          SETTLE_TICKS = 8;
  localparam logic [7:0]  REG_SPARE    = 8'd2;
  localparam logic [7:0]  REG_TOP      = 8'hFF;

  // one expected symbol slot
  typedef struct packed {
    sym_kind_t kind;
    logic      sda_level;
    logic      end_flag;
  } symbol_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [15:0] s_tdata = '0;
  logic       s_tuser = 1'b0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // shadow of the configuration registers
  logic       colour_normal = NORMAL_COLOUR_RST;
  logic [7:0] dev_addr = DEV_ADDR_RST;

  symbol_t    pending_symbols[$];
  symbol_t    want;
  int         fail_count = 0;
  int         requests_sent = 0;
  int         symbols_checked = 0;
  int         reg_writes = 0;
  int         cycle_count = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;

  display_i2c_write_framer_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_display_i2c_write_framer_core failed");
      $finish;
    end
  end

  // random backpressure on the symbol stream
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // slot expansion
  // ---------------------------------------------------------------------------
  function automatic void queue_slot(sym_kind_t k, logic lvl);
    symbol_t s;
    s.kind = k;
    s.sda_level = lvl;
    s.end_flag = 1'b0;
    pending_symbols.push_back(s);
  endfunction

  // eight bits msb first, then the ack slot holding the last bit
  function automatic void queue_byte(logic [7:0] b);
    for (int i = 7; i >= 0; i--) queue_slot(KIND_BIT, b[i]);
    queue_slot(KIND_ACK, b[0]);
  endfunction

  function automatic void expand_request(logic req, logic [7:0] b, logic first,
                                         logic last);
    symbol_t tail;
    if (req == REQ_COMMAND) begin
      queue_slot(KIND_START, 1'b0);
      queue_byte(dev_addr);
      queue_byte(CTRL_COMMAND);
      queue_byte(b);
      queue_slot(KIND_STOP, 1'b0);
    end else begin
      if (first) begin
        queue_slot(KIND_START, 1'b0);
        queue_byte(dev_addr);
        queue_byte(CTRL_DATA);
      end
      queue_byte(colour_normal ? b : ~b);
      if (last) queue_slot(KIND_STOP, 1'b0);
    end
    // mark the final slot of this request
    tail = pending_symbols.pop_back();
    tail.end_flag = 1'b1;
    pending_symbols.push_back(tail);
  endfunction

  // ---------------------------------------------------------------------------
  // symbol monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_symbols.size() == 0) begin
        $error("unexpected symbol word: kind %0d level %0d last %0d",
               m_tdata[1:0], m_tdata[2], m_tlast);
        fail_count++;
      end else begin
        want = pending_symbols.pop_front();
        symbols_checked++;
        if (m_tdata[1:0] != want.kind) begin
          $error("symbol_kind: expected %0d, got %0d", want.kind, m_tdata[1:0]);
          fail_count++;
        end
        if (m_tdata[2] != want.sda_level) begin
          $error("bit_level: expected %0d, got %0d", want.sda_level, m_tdata[2]);
          fail_count++;
        end
        if (m_tlast != want.end_flag) begin
          $error("last_symbol: expected %0d, got %0d", want.end_flag, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers; every task starts and ends at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_request(logic req, logic [7:0] b, logic first, logic last);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, first, b};
    s_tuser  <= req;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    expand_request(req, b, first, last);
    requests_sent++;
    @(negedge clk);
  endtask

  // hold the request stream until every pending symbol has arrived
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_symbols.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // write one register, then leave the channel idle
  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_NORMAL_COLOUR) colour_normal = val[0];
    else if (idx == REG_DEV_ADDR) dev_addr = val;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults();
    send_request(REQ_COMMAND, 8'h3C, 1'b0, 1'b0);
    send_request(REQ_DATA, 8'h96, 1'b1, 1'b1);
    wait_drained();
  endtask

  // command flags must be ignored
  task automatic test_command_requests();
    send_request(REQ_COMMAND, 8'h00, 1'b0, 1'b0);
    send_request(REQ_COMMAND, 8'hFF, 1'b1, 1'b1);
    send_request(REQ_COMMAND, 8'h81, 1'b1, 1'b0);
    wait_drained();
  endtask

  task automatic test_data_framing();
    send_request(REQ_DATA, 8'h00, 1'b1, 1'b0);
    send_request(REQ_DATA, 8'hFF, 1'b0, 1'b0);
    send_request(REQ_DATA, 8'h01, 1'b0, 1'b0);
    send_request(REQ_DATA, 8'h80, 1'b0, 1'b1);
    send_request(REQ_DATA, 8'h7E, 1'b1, 1'b1);
    // close without an open transaction
    send_request(REQ_DATA, 8'h55, 1'b0, 1'b1);
    wait_drained();
  endtask

  // data inverted, command and framing bytes untouched
  task automatic test_inverted_colour();
    write_reg(REG_NORMAL_COLOUR, 8'hFE);
    send_request(REQ_COMMAND, 8'hA5, 1'b0, 1'b0);
    send_request(REQ_DATA, 8'h0F, 1'b1, 1'b1);
    send_request(REQ_DATA, 8'hFF, 1'b0, 1'b0);
    wait_drained();
    write_reg(REG_NORMAL_COLOUR, 8'h01);
  endtask

  task automatic test_address_extremes();
    write_reg(REG_DEV_ADDR, 8'h00);
    send_request(REQ_COMMAND, 8'h12, 1'b0, 1'b0);
    send_request(REQ_DATA, 8'h34, 1'b1, 1'b1);
    wait_drained();
    write_reg(REG_DEV_ADDR, 8'hFF);
    send_request(REQ_COMMAND, 8'h12, 1'b0, 1'b0);
    send_request(REQ_DATA, 8'h34, 1'b1, 1'b1);
    wait_drained();
  endtask

  // writes to indexes past the register file change nothing
  task automatic test_unused_register_index();
    write_reg(REG_SPARE, 8'h00);
    write_reg(REG_TOP, 8'hFF);
    send_request(REQ_COMMAND, 8'h5A, 1'b0, 1'b0);
    send_request(REQ_DATA, 8'hC3, 1'b1, 1'b1);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // random traffic: mostly whole transactions, some loose data words
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(int n_req, int gap, int stall);
    int done;
    int pick;
    int len;
    done = 0;
    gap_pct = gap;
    stall_pct = stall;
    while (done < n_req) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_request(REQ_COMMAND, 8'($urandom), 1'($urandom), 1'($urandom));
        done++;
      end else if (pick < 82) begin
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++)
          send_request(REQ_DATA, 8'($urandom), i == 0, i == len - 1);
        done += len;
      end else begin
        send_request(REQ_DATA, 8'($urandom), 1'($urandom), 1'($urandom));
        done++;
      end
      // occasionally let the block run dry mid-phase
      if ($urandom_range(99) < 4) wait_drained();
    end
    wait_drained();
    gap_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_command_requests();
    test_data_framing();
    test_inverted_colour();
    test_address_extremes();
    test_unused_register_index();

    write_reg(REG_DEV_ADDR, DEV_ADDR_RST);
    test_random_traffic(112, 0, 0);
    write_reg(REG_NORMAL_COLOUR, 8'h00);
    write_reg(REG_DEV_ADDR, 8'hFF);
    test_random_traffic(112, 88, 0);
    write_reg(REG_NORMAL_COLOUR, 8'h01);
    write_reg(REG_DEV_ADDR, 8'h00);
    test_random_traffic(112, 0, 88);
    write_reg(REG_NORMAL_COLOUR, 8'h00);
    write_reg(REG_DEV_ADDR, 8'($urandom));
    test_random_traffic(112, 35, 35);

    $display("covered %0d requests, %0d symbol words, %0d register writes",
             requests_sent, symbols_checked, reg_writes);
    $display("idle/stall mixes 0/0, 88/0, 0/88, 35/35; %0d failures", fail_count);
    if (fail_count == 0) begin
      $display("tb_display_i2c_write_framer_core passed");
    end else begin
      $display("tb_display_i2c_write_framer_core failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
sv/di2cwf_pkg.sv
sv/display_i2c_write_framer_core.sv
test/tb_display_i2c_write_framer_core.sv
